// File: src/vl2n_pkg.sv
// shared types and constants for the vector l2 normaliser
// no dependencies
`default_nettype none

package vl2n_pkg;

    // fixed widths of the result fields and of the running sum
    localparam int SUM_W       = 40;
    localparam int OUT_W       = 16;
    localparam int IDX_OUT_W   = 6;

    // quotient bits of the scaled square and result bits of its root
    localparam int DIV_STEPS   = 30;
    localparam int SQRT_STEPS  = 15;
    localparam int STEP_W      = 5;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [OUT_W-1:0] POS_MAX = 16'h7fff;
    localparam logic [OUT_W-1:0] Q_ONE   = 16'h8000;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_READ,
        S_SQ,
        S_CMP,
        S_DIV,
        S_SQRT,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// File: src/vector_l2_normalizer.sv
// vector l2 normaliser: element store, sum of squares and serial rsqrt scaling
// depends on vl2n_pkg
`default_nettype none

// Elements are taken one per request while busy is low; each request keeps
// busy high in S_ACC while its square is added to the sum, and no element
// is taken then. The request marked last starts the emission: every stored
// element is read back from the element store, its square is divided by the
// sum of squares one quotient bit a cycle and the square root of that
// quotient is taken two quotient bits a cycle; a result passes read, square,
// check, division, root and output, and a zero vector or an element whose
// square reaches the sum skips the division and root. Each result is shown
// for one cycle with o_valid high and the receiver cannot stall it; busy
// stays high until the last result has gone. Elements past MAX_LEN are
// dropped and every result of that vector has o_overflow_flag set.
module vector_l2_normalizer #(
    parameter int MAX_LEN    = 64,
    parameter int ELEM_WIDTH = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  signed [ELEM_WIDTH-1:0]     i_element_value,
    input  wire                              i_is_last,
    output logic                             o_valid,
    output logic signed [vl2n_pkg::OUT_W-1:0] o_normalized_value,
    output logic [vl2n_pkg::IDX_OUT_W-1:0]   o_element_index,
    output logic                             o_last_result,
    output logic                             o_overflow_flag
);
    import vl2n_pkg::*;

    localparam int W     = ELEM_WIDTH;
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SW    = ((2 * W > SUM_W) ? 2 * W : SUM_W) + 1;

    // element store
    logic [W-1:0]       mem [MAX_LEN];
    logic [W-1:0]       r_rd_data;

    t_state             r_state,   n_state;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic [SUM_W-1:0]   r_sum,     n_sum;
    logic               r_dropped, n_dropped;
    logic               r_take,    n_take;
    logic               r_last,    n_last;
    logic [IDX_W-1:0]   r_idx,     n_idx;
    logic [2*W-1:0]     r_sq,      n_sq;
    logic               r_neg,     n_neg;
    logic [SUM_W-1:0]   r_rem,     n_rem;
    logic [DIV_STEPS-1:0] r_quo,   n_quo;
    logic [OUT_W-1:0]   r_q,       n_q;
    logic [STEP_W-1:0]  r_step,    n_step;

    logic               accept;
    logic [W-1:0]       mul_src;
    logic [W-1:0]       mag;
    logic [SW-1:0]      sum_x;
    logic [SW-1:0]      sq_x;
    logic [SUM_W:0]     div_rem2;
    logic [SUM_W:0]     div_diff;
    logic [18:0]        sq_rem;
    logic [16:0]        sq_test;
    logic [18:0]        sq_diff;
    logic               idx_last;

    assign accept = start && (r_state == S_IDLE);

    // store write on accept and registered read at the emission index
    always_ff @(posedge i_clk) begin
        if (accept && (r_count < CNT_W'(MAX_LEN))) begin
            mem[r_count[IDX_W-1:0]] <= i_element_value;
        end
        r_rd_data <= mem[r_idx];
    end

    // shared squarer: input element while loading, stored element on emission
    always_comb begin
        mul_src = (r_state == S_IDLE) ? i_element_value : r_rd_data;
        mag     = mul_src[W-1] ? (~mul_src + 1'b1) : mul_src;
    end

    assign sum_x    = SW'(r_sum) + SW'(r_sq);
    assign sq_x     = SW'(r_sq);
    assign div_rem2 = {r_rem, 1'b0};
    assign div_diff = div_rem2 - {1'b0, r_sum};
    assign sq_rem   = {r_rem[16:0], r_quo[DIV_STEPS-1 -: 2]};
    assign sq_test  = {r_q[14:0], 2'b01};
    assign sq_diff  = sq_rem - 19'(sq_test);
    assign idx_last = (CNT_W'(r_idx) + 1'b1) == r_count;

    // next state and datapath
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_sum     = r_sum;
        n_dropped = r_dropped;
        n_take    = r_take;
        n_last    = r_last;
        n_idx     = r_idx;
        n_sq      = r_sq;
        n_neg     = r_neg;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_q       = r_q;
        n_step    = r_step;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_last = i_is_last;
                    n_sq   = (2*W)'(mag) * (2*W)'(mag);
                    if (r_count < CNT_W'(MAX_LEN)) begin
                        n_take  = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_take    = 1'b0;
                        n_dropped = 1'b1;
                    end
                    n_state = S_ACC;
                end
            end
            // saturating accumulate of the element square
            S_ACC: begin
                if (r_take) begin
                    n_sum = (sum_x > SW'(SUM_MAX)) ? SUM_MAX : sum_x[SUM_W-1:0];
                end
                if (r_last) begin
                    n_idx   = '0;
                    n_state = S_READ;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // wait for the registered store read
            S_READ: begin
                n_state = S_SQ;
            end
            S_SQ: begin
                n_sq    = (2*W)'(mag) * (2*W)'(mag);
                n_neg   = r_rd_data[W-1];
                n_state = S_CMP;
            end
            // zero vector and full-scale cases, else start the division
            S_CMP: begin
                n_step = '0;
                n_quo  = '0;
                if (r_sum == '0) begin
                    n_q     = '0;
                    n_state = S_OUT;
                end else if (sq_x >= SW'(r_sum)) begin
                    n_q     = Q_ONE;
                    n_state = S_OUT;
                end else begin
                    n_rem   = sq_x[SUM_W-1:0];
                    n_q     = '0;
                    n_state = S_DIV;
                end
            end
            // restoring division of square * 2^30 by the sum, one bit a cycle
            S_DIV: begin
                if (!div_diff[SUM_W]) begin
                    n_rem = div_diff[SUM_W-1:0];
                    n_quo = {r_quo[DIV_STEPS-2:0], 1'b1};
                end else begin
                    n_rem = div_rem2[SUM_W-1:0];
                    n_quo = {r_quo[DIV_STEPS-2:0], 1'b0};
                end
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_rem   = '0;
                    n_state = S_SQRT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            // digit-recurrence square root, two quotient bits a cycle
            S_SQRT: begin
                n_quo = {r_quo[DIV_STEPS-3:0], 2'b00};
                if (!sq_diff[18]) begin
                    n_rem = SUM_W'(sq_diff);
                    n_q   = {r_q[14:0], 1'b1};
                end else begin
                    n_rem = SUM_W'(sq_rem);
                    n_q   = {r_q[14:0], 1'b0};
                end
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            // one result out, then next element or back to idle
            S_OUT: begin
                if (idx_last) begin
                    n_count   = '0;
                    n_sum     = '0;
                    n_dropped = 1'b0;
                    n_state   = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_sum     <= '0;
            r_dropped <= 1'b0;
            r_take    <= 1'b0;
            r_last    <= 1'b0;
            r_idx     <= '0;
            r_step    <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_dropped <= n_dropped;
            r_take    <= n_take;
            r_last    <= n_last;
            r_idx     <= n_idx;
            r_step    <= n_step;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_sq  <= n_sq;
        r_neg <= n_neg;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_q   <= n_q;
    end

    // result ports with sign and saturation
    always_comb begin
        busy            = (r_state != S_IDLE);
        o_valid         = (r_state == S_OUT);
        o_element_index = IDX_OUT_W'(r_idx);
        o_last_result   = idx_last;
        o_overflow_flag = r_dropped;
        if (r_neg) begin
            o_normalized_value = -r_q;
        end else if (r_q[OUT_W-1]) begin
            o_normalized_value = POS_MAX;
        end else begin
            o_normalized_value = r_q;
        end
    end

endmodule

`default_nettype wire
